/* rtl/pair_interning_hash_table_macros.svh */
// assertion macros for the pair interning table
// used by the top level only; empty when SYNTHESIS is defined
`ifndef PAIR_INTERNING_HASH_TABLE_MACROS_SVH
`define PAIR_INTERNING_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define PIHT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PIHT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PIHT_ASSERT_IMP(label, clk, rst, ante, cons)
`define PIHT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/piht_pkg.sv */
// shared types, codes and hash constant for the pair interning table
// no dependencies
package piht_pkg;
  localparam int ENTRIES_DEF  = 1024;
  localparam int SLOTS_DEF    = 2048;
  localparam int KEY_BITS_DEF = 31;
  localparam int HASH_MUL     = 16807;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] key_a;
    logic [30:0] key_b;
    logic [9:0]  query_index;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  entry_index;
    logic [30:0] pair_a;
    logic [30:0] pair_b;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_MOD, S_RDSLOT, S_RDREC, S_CHECK,
    S_WRITE, S_RDQ, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic hash1;     // first multiply
    logic hash2;     // second multiply
    logic modstep;   // reduce mod slots
    logic clr_step;  // clear one slot
    logic rd_slot;   // read slot at probe pointer
    logic rd_rec;    // read record at slot entry
    logic step;      // move probe downward
    logic ins;       // write record and slot
    logic rd_q;      // read record at query index
    logic set_res;   // load result register
    logic [2:0] res_status;
    logic res_use_q; // result index from query
    logic res_pair;  // result carries record keys
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic slot_empty;
    logic match;
    logic probe_done; // all slots visited
    logic store_full;
    logic q_ok;
  } sts_t;
endpackage

/* rtl/piht_ctrl.sv */
// controller state machine for the pair interning table
// depends on piht_pkg
module piht_ctrl import piht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [1:0] action,
  input  logic      res_busy,
  input  sts_t      sts,
  output logic      in_ready,
  output cmd_t      cmd
);
  state_t state, state_next;
  logic [1:0] act;

  // state and captured action
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      act <= ACT_INSERT;
    end else begin
      state <= state_next;
      if (in_ready && in_valid) act <= action;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (action inside {ACT_INSERT, ACT_LOOKUP}) state_next = S_HASH1;
          else if (action == ACT_READ) state_next = S_RDQ;
          else state_next = S_DONE;
        end
      end
      S_HASH1: begin cmd.hash1 = 1'b1; state_next = S_HASH2; end
      S_HASH2: begin cmd.hash2 = 1'b1; state_next = S_MOD; end
      S_MOD: begin
        cmd.modstep = 1'b1;
        if (sts.mod_done) state_next = S_RDSLOT;
      end
      S_RDSLOT: begin cmd.rd_slot = 1'b1; state_next = S_RDREC; end
      S_RDREC: begin cmd.rd_rec = 1'b1; state_next = S_CHECK; end
      S_CHECK: begin
        if (!res_busy) begin
          if (sts.slot_empty) begin
            if (act == ACT_LOOKUP) begin
              cmd.set_res = 1'b1; cmd.res_status = ST_NOTFOUND; state_next = S_IDLE;
            end else if (sts.store_full) begin
              cmd.set_res = 1'b1; cmd.res_status = ST_FULL; state_next = S_IDLE;
            end else state_next = S_WRITE;
          end else if (sts.match) begin
            cmd.set_res = 1'b1; cmd.res_status = ST_FOUND; state_next = S_IDLE;
          end else if (sts.probe_done) begin
            cmd.set_res = 1'b1;
            cmd.res_status = (act == ACT_LOOKUP) ? ST_NOTFOUND : ST_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1; state_next = S_RDSLOT;
          end
        end
      end
      S_WRITE: begin
        cmd.ins = 1'b1; cmd.set_res = 1'b1; cmd.res_status = ST_NEW;
        state_next = S_IDLE;
      end
      S_RDQ: begin cmd.rd_q = 1'b1; state_next = S_DONE; end
      S_DONE: begin
        if (!res_busy) begin
          cmd.set_res = 1'b1;
          if (act == ACT_READ && sts.q_ok) begin
            cmd.res_status = ST_FOUND; cmd.res_use_q = 1'b1; cmd.res_pair = 1'b1;
          end else cmd.res_status = ST_INVALID;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/piht_dp.sv */
// datapath: hash, slot memory, record memories, probe pointer, result register
// depends on piht_pkg
module piht_dp import piht_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_beat_t  in_beat,
  input  logic      out_stall,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      res_busy,
  output logic      out_valid,
  output out_beat_t out_beat
);
  localparam int SW = $clog2(SLOTS);
  localparam int EW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int HW = 31;
  localparam int RS = HW + SW;
  localparam logic [63:0] RECIP = (64'd1 << RS) / 64'(SLOTS);
  localparam logic [HW-1:0] SLOTS_H = HW'(SLOTS);
  localparam logic [SW-1:0] TOP = SW'(SLOTS - 1);

  logic [KEY_BITS-1:0] ka, kb;
  logic [9:0] qidx;
  logic [HW-1:0] hval;
  logic [HW-1:0] hsh;       // full hash before reduction
  logic [31:0]   qest;      // estimated quotient
  logic [HW-1:0] rem;       // remainder being reduced
  logic [1:0]    mphase;
  logic [SW-1:0] ptr;
  logic [PW-1:0] visited;
  logic [CW-1:0] count;
  logic [SW:0]   clr_ptr;
  logic [EW-1:0] slot_mem [SLOTS];
  logic          slot_vld [SLOTS];
  logic [KEY_BITS-1:0] fk_mem [ENTRIES];
  logic [KEY_BITS-1:0] sk_mem [ENTRIES];
  logic [EW-1:0] slot_e;
  logic          slot_v;
  logic [KEY_BITS-1:0] rec_a, rec_b;
  logic [47:0]   prod;

  // hash multiplier, one 31x15 product per step
  always_comb begin
    if (cmd.hash1) prod = 48'(HASH_MUL) * 48'(ka);
    else prod = 48'(HASH_MUL) * 48'(hval);
  end

  // key capture, hash, and reduction mod slots by reciprocal multiply
  // with one corrective subtraction: quotient estimate, remainder, correction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ka <= in_beat.key_a[KEY_BITS-1:0];
      kb <= in_beat.key_b[KEY_BITS-1:0];
      qidx <= in_beat.query_index;
    end
    if (cmd.hash1) hval <= HW'(prod[HW-1:0] + 48'(kb));
    if (cmd.hash2) begin
      hsh <= prod[HW-1:0];
      mphase <= 2'd0;
    end
    if (cmd.modstep) begin
      case (mphase)
        2'd0: qest <= 32'((64'(hsh) * RECIP) >> RS);
        2'd1: rem <= hsh - HW'(64'(qest) * 64'(SLOTS));
        2'd2: if (rem >= SLOTS_H) rem <= rem - SLOTS_H;
        default: ;
      endcase
      if (mphase != 2'd3) mphase <= mphase + 2'd1;
    end
  end
  assign sts.mod_done = (mphase == 2'd3);

  // probe pointer and visit count
  always_ff @(posedge clk) begin
    if (cmd.modstep && sts.mod_done) begin
      ptr <= SW'(rem);
      visited <= '0;
    end else if (cmd.step) begin
      ptr <= (ptr == '0) ? TOP : ptr - 1'b1;
    end
    if (cmd.rd_slot) visited <= visited + 1'b1;
  end
  assign sts.probe_done = (visited == PW'(SLOTS));

  // slot memories and clearing pass
  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (cmd.clr_step && !sts.clr_done) clr_ptr <= clr_ptr + 1'b1;
    if (cmd.clr_step) slot_vld[clr_ptr[SW-1:0]] <= 1'b0;
    else if (cmd.ins) begin
      slot_vld[ptr] <= 1'b1;
      slot_mem[ptr] <= count[EW-1:0];
    end
    if (cmd.rd_slot) begin
      slot_e <= slot_mem[ptr];
      slot_v <= slot_vld[ptr];
    end
  end
  assign sts.clr_done = (clr_ptr == (SW+1)'(SLOTS - 1));

  // record memories
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      fk_mem[count[EW-1:0]] <= ka;
      sk_mem[count[EW-1:0]] <= kb;
    end
    if (cmd.rd_rec) begin
      rec_a <= fk_mem[slot_e];
      rec_b <= sk_mem[slot_e];
    end else if (cmd.rd_q) begin
      rec_a <= fk_mem[EW'(qidx)];
      rec_b <= sk_mem[EW'(qidx)];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.ins) count <= count + 1'b1;
  end

  assign sts.slot_empty = !slot_v;
  assign sts.match = (CW'(slot_e) < count) && rec_a == ka && rec_b == kb;
  assign sts.store_full = (count >= CW'(ENTRIES));
  assign sts.q_ok = (32'(qidx) < 32'(count));

  // result register
  assign res_busy = out_valid && out_stall;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.set_res) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.set_res) begin
      out_beat.status <= cmd.res_status;
      out_beat.entry_index <= '0;
      out_beat.pair_a <= '0;
      out_beat.pair_b <= '0;
      if (cmd.res_status == ST_FOUND) out_beat.entry_index <= 10'(slot_e);
      if (cmd.res_status == ST_NEW) out_beat.entry_index <= 10'(count);
      if (cmd.res_use_q) out_beat.entry_index <= qidx;
      if (cmd.res_pair) begin
        out_beat.pair_a <= 31'(rec_a);
        out_beat.pair_b <= 31'(rec_b);
      end
    end
  end
endmodule

/* rtl/pair_interning_hash_table.sv */
// pair interning table: interns key pairs as dense indices
// one beat in on the in channel, one result beat out on the out channel;
// insert and lookup hash (two multiplies, then a reduction mod
// SLOTS by reciprocal multiply) and probe the slot table downward,
// reading the slot, then its record, then checking, per slot visited;
// a hit or miss loads its result from the check state, a new pair
// from the write state after it; a read passes the query read and
// done states, an unused action the done state only; one item at a
// time; the next beat is taken once the result is loaded into the
// output register, which holds while out_stall is high; a new result
// waits in the controller until the held one is taken; after reset a
// clearing pass empties all slots; no input beat is taken during it
// depends on piht_pkg, piht_ctrl, piht_dp and the macro header
`include "pair_interning_hash_table_macros.svh"
module pair_interning_hash_table import piht_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);
  cmd_t cmd;
  sts_t sts;
  logic res_busy, in_ready;

  piht_ctrl u_ctrl (
    .clk, .rst, .in_valid, .action(in_data.action), .res_busy, .sts,
    .in_ready, .cmd
  );

  piht_dp #(.ENTRIES(ENTRIES), .SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk, .rst, .in_beat(in_data), .out_stall, .cmd, .sts, .res_busy,
    .out_valid, .out_beat(out_data)
  );

  assign in_stall = !in_ready;

  // checks
  `PIHT_ASSERT_IMP(a_res_not_lost, clk, rst, cmd.set_res, !res_busy)
  `PIHT_ASSERT_NXT(a_res_valid, clk, rst, cmd.set_res, out_valid)
  `PIHT_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.ins, cmd.step, cmd.load}))
endmodule
